@@ sv/holt_joint_smoother_defines.svh @@
// ----------------------------------------------------------------------------
// holt_joint_smoother assertion macros
// Shared concurrent assertion forms. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef HOLT_JOINT_SMOOTHER_DEFINES_SVH
`define HOLT_JOINT_SMOOTHER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define HJS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define HJS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/hjs_pkg.sv @@
// ----------------------------------------------------------------------------
// hjs_pkg
// Shared constants, types and saturation helper of the joint smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package hjs_pkg;

  // Slot count and derived address width
  localparam int JOINT_COUNT = 7;
  localparam int ADDR_W      = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  // Field widths
  localparam int IDX_W       = 3;
  localparam int COORD_COUNT = 5;
  localparam int SAMPLE_W    = 17;   // common signed width of all coordinates
  localparam int XQ_W        = SAMPLE_W + 8;  // sample in Q.8
  localparam int STORE_W     = 26;   // smoothed / trend word, Q.8 signed
  localparam int SUM_W       = 31;   // headroom for adds before saturation
  localparam int DIFF_W      = 28;   // differences fed to the multiplier
  localparam int TSUM_W      = 27;   // level plus trend
  localparam int FACTOR_W    = 17;
  localparam int PROD_W      = FACTOR_W + 1 + DIFF_W;
  localparam int HOLD_W      = 8;
  localparam int DATA_W      = 72;
  localparam int USER_W      = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int NUM_STAGES  = 5;

  // Factor of one in Q1.16
  localparam logic [FACTOR_W-1:0] ONE_Q16 = {1'b1, {(FACTOR_W-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_FACTOR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LIMIT       = 2'd1;

  // Per-item update kind seen by the coordinate lanes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_NONE   = 2'd0;  // no store write
  localparam mode_t MODE_FIRST  = 2'd1;  // level := sample
  localparam mode_t MODE_SECOND = 2'd2;  // trend := sample - level
  localparam mode_t MODE_HOLT   = 2'd3;  // full Holt update

  // Slot tracker decision for one transaction
  typedef struct packed {
    mode_t mode;
    logic  jvalid;
  } slot_ctl_t;

  // Control carried along the lane pipeline
  typedef struct packed {
    logic             vld;
    logic             wr;
    logic             jvalid;
    logic [IDX_W-1:0] idx;
  } stage_ctl_t;

  // Saturate a wide sum to the store range
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-STORE_W+1){1'b0}}, {(STORE_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-STORE_W+1){1'b1}}, {(STORE_W-1){1'b0}}};

  function automatic logic signed [STORE_W-1:0] sat_store(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [STORE_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[STORE_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[STORE_W-1:0];
    end else begin
      r = v[STORE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/holt_joint_smoother.sv @@
// ----------------------------------------------------------------------------
// holt_joint_smoother
// Per-joint Holt double exponential smoothing of tracked skeleton frames.
// ----------------------------------------------------------------------------
// Usage: send one transaction per joint slot on in_* (tuser holds index and
// present flag, tdata the five coordinates). Every input transaction gives
// exactly one result transaction on out_*, in order. Five coordinate lanes
// run the update side by side; a merge stage packs their levels.
// The accepting edge loads the first of five lane stages, and the output
// register follows the last of them.
// One transaction per cycle while the receiver does not stall, as long as the
// same slot does not return while its store write is in flight; a slot still
// being written back to its store holds in_tready low until the write is done.
// With 7 slots sent in turn the block runs at full rate.
// cfg_* writes smoothing_factor (index 0) and hold_limit (index 1); cfg_ready
// is always high. Write only while no transaction is in flight.
// Reset (rst_n low, synchronous) clears all slot valid marks, hold counters
// and pipeline valids and loads factor 0.5 and hold limit 3.
// When the receiver stalls, the whole pipeline holds and in_tready drops
// once the output register is full; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "holt_joint_smoother_defines.svh"

module holt_joint_smoother (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tuser: [2:0] joint_index, [3] joint_present
  // in_tdata: [15:0] x_in, [31:16] y_in, [47:32] z_in,
  //           [59:48] screen_x_in, [71:60] screen_y_in
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [hjs_pkg::USER_W-1:0]         in_tuser,
  input  wire logic [hjs_pkg::DATA_W-1:0]         in_tdata,
  // out_tuser: [2:0] joint_index_out, [3] joint_valid
  // out_tdata: [15:0] x_out, [31:16] y_out, [47:32] z_out,
  //            [59:48] screen_x_out, [71:60] screen_y_out
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [hjs_pkg::USER_W-1:0]              out_tuser,
  output logic [hjs_pkg::DATA_W-1:0]              out_tdata,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [hjs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [hjs_pkg::FACTOR_W-1:0]       cfg_data
);

  // Configuration registers
  logic [hjs_pkg::FACTOR_W-1:0] factor_r;
  logic [hjs_pkg::HOLD_W-1:0]   hold_limit_r;
  logic [hjs_pkg::FACTOR_W-1:0] factor_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r     <= hjs_pkg::FACTOR_W'(32768);
      hold_limit_r <= hjs_pkg::HOLD_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hjs_pkg::REG_SMOOTHING_FACTOR: factor_r     <= cfg_data;
        hjs_pkg::REG_HOLD_LIMIT:       hold_limit_r <= cfg_data[hjs_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // A factor above one acts as one
  assign factor_eff = (factor_r > hjs_pkg::ONE_Q16) ? hjs_pkg::ONE_Q16 : factor_r;

  // Input fields
  logic [hjs_pkg::IDX_W-1:0]  in_idx;
  logic                       in_present;
  logic [hjs_pkg::ADDR_W-1:0] in_addr;
  logic                       acc;
  logic                       adv;
  logic                       hazard;

  assign in_idx     = in_tuser[2:0];
  assign in_present = in_tuser[3];
  assign in_addr    = hjs_pkg::ADDR_W'(in_idx);

  // Pipeline moves whenever the output register can take a result
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv && !hazard;
  assign acc       = in_tvalid && in_tready;

  // Slot tracker
  hjs_pkg::slot_ctl_t slot_ctl;

  hjs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .idx        (in_idx),
    .present    (in_present),
    .hold_limit (hold_limit_r),
    .ctl        (slot_ctl)
  );

  // Stage control alongside the lanes
  hjs_pkg::stage_ctl_t stg_r [hjs_pkg::NUM_STAGES];
  hjs_pkg::stage_ctl_t stg_in;

  always_comb begin
    stg_in.vld    = acc;
    stg_in.wr     = slot_ctl.mode != hjs_pkg::MODE_NONE;
    stg_in.jvalid = slot_ctl.jvalid;
    stg_in.idx    = in_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < hjs_pkg::NUM_STAGES; k++) begin
        stg_r[k] <= '0;
      end
    end else if (adv) begin
      stg_r[0] <= stg_in;
      for (int k = 1; k < hjs_pkg::NUM_STAGES; k++) begin
        stg_r[k] <= stg_r[k-1];
      end
    end
  end

  // Hold the input while its slot still has a store write in flight
  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < hjs_pkg::NUM_STAGES; k++) begin
      if (stg_r[k].vld && stg_r[k].wr && (stg_r[k].idx == in_idx)) begin
        hazard = 1'b1;
      end
    end
  end

  // Coordinate lanes
  logic signed [hjs_pkg::SAMPLE_W-1:0] lane_sample [hjs_pkg::COORD_COUNT];
  logic signed [hjs_pkg::STORE_W-1:0]  lane_level  [hjs_pkg::COORD_COUNT];
  hjs_pkg::mode_t                      lane_mode;

  assign lane_sample[0] = hjs_pkg::SAMPLE_W'($signed(in_tdata[15:0]));
  assign lane_sample[1] = hjs_pkg::SAMPLE_W'($signed(in_tdata[31:16]));
  assign lane_sample[2] = hjs_pkg::SAMPLE_W'($signed(in_tdata[47:32]));
  assign lane_sample[3] = {5'd0, in_tdata[59:48]};
  assign lane_sample[4] = {5'd0, in_tdata[71:60]};
  assign lane_mode      = acc ? slot_ctl.mode : hjs_pkg::MODE_NONE;

  for (genvar c = 0; c < hjs_pkg::COORD_COUNT; c++) begin : g_lane
    hjs_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_mode   (lane_mode),
      .in_addr   (in_addr),
      .in_sample (lane_sample[c]),
      .factor    (factor_eff),
      .level_out (lane_level[c])
    );
  end

  // Merge and output register
  hjs_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .last_ctl   (stg_r[hjs_pkg::NUM_STAGES-1]),
    .level      (lane_level),
    .out_tvalid (out_tvalid),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // Checks
  `HJS_ASSERT_IMPLY(a_valid_in_range, out_tvalid && out_tuser[3],
    32'(out_tuser[2:0]) < hjs_pkg::JOINT_COUNT, "valid result for a slot out of range")
  `HJS_ASSERT_IMPLY(a_empty_is_zero, out_tvalid && !out_tuser[3],
    out_tdata == '0, "empty slot result carries nonzero coordinates")
  `HJS_ASSERT_IMPLY(a_one_writer_per_slot, stg_r[0].vld && stg_r[0].wr,
    !((stg_r[1].vld && stg_r[1].wr && stg_r[1].idx == stg_r[0].idx) ||
      (stg_r[2].vld && stg_r[2].wr && stg_r[2].idx == stg_r[0].idx) ||
      (stg_r[3].vld && stg_r[3].wr && stg_r[3].idx == stg_r[0].idx) ||
      (stg_r[4].vld && stg_r[4].wr && stg_r[4].idx == stg_r[0].idx)),
    "two store writes to one slot in flight")
  `HJS_ASSERT_NEXT(a_result_follows, stg_r[hjs_pkg::NUM_STAGES-1].vld && adv,
    out_tvalid && (out_tuser[2:0] == $past(stg_r[hjs_pkg::NUM_STAGES-1].idx)),
    "lane result did not reach the output register")

endmodule

`default_nettype wire

@@ sv/hjs_ctrl.sv @@
// ----------------------------------------------------------------------------
// hjs_ctrl
// Slot tracker: valid marks and hold counters, decides each update kind.
// ----------------------------------------------------------------------------
`default_nettype none

module hjs_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          acc,
  input  wire logic [hjs_pkg::IDX_W-1:0]     idx,
  input  wire logic                          present,
  input  wire logic [hjs_pkg::HOLD_W-1:0]    hold_limit,
  output hjs_pkg::slot_ctl_t                 ctl
);

  logic [hjs_pkg::JOINT_COUNT-1:0] sv_r, sv_nxt;
  logic [hjs_pkg::JOINT_COUNT-1:0] tv_r, tv_nxt;
  logic [hjs_pkg::HOLD_W-1:0]      hc_r   [hjs_pkg::JOINT_COUNT];
  logic [hjs_pkg::HOLD_W-1:0]      hc_nxt [hjs_pkg::JOINT_COUNT];

  logic [hjs_pkg::ADDR_W-1:0] addr;
  logic                       in_range;
  logic                       sv_cur, tv_cur;
  logic [hjs_pkg::HOLD_W-1:0] hc_cur;

  assign addr     = hjs_pkg::ADDR_W'(idx);
  assign in_range = 32'(idx) < hjs_pkg::JOINT_COUNT;
  assign sv_cur   = in_range ? sv_r[addr] : 1'b0;
  assign tv_cur   = in_range ? tv_r[addr] : 1'b0;
  assign hc_cur   = in_range ? hc_r[addr] : '0;

  // Decision for the item on the input
  always_comb begin
    ctl.mode   = hjs_pkg::MODE_NONE;
    ctl.jvalid = 1'b0;
    if (in_range) begin
      if (present) begin
        ctl.jvalid = 1'b1;
        if (!sv_cur) begin
          ctl.mode = hjs_pkg::MODE_FIRST;
        end else if (!tv_cur) begin
          ctl.mode = hjs_pkg::MODE_SECOND;
        end else begin
          ctl.mode = hjs_pkg::MODE_HOLT;
        end
      end else begin
        // absent joint keeps showing while the hold lasts
        ctl.jvalid = sv_cur && (hc_cur != '0);
      end
    end
  end

  // Slot state update
  always_comb begin
    sv_nxt = sv_r;
    tv_nxt = tv_r;
    hc_nxt = hc_r;
    if (acc && in_range) begin
      if (present) begin
        hc_nxt[addr] = hold_limit;
        if (!sv_cur) begin
          sv_nxt[addr] = 1'b1;
        end else if (!tv_cur) begin
          tv_nxt[addr] = 1'b1;
        end
      end else if (sv_cur || tv_cur) begin
        if (hc_cur != '0) begin
          hc_nxt[addr] = hc_cur - 1'b1;
        end else begin
          sv_nxt[addr] = 1'b0;
          tv_nxt[addr] = 1'b0;
          hc_nxt[addr] = hold_limit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      tv_r <= '0;
      for (int i = 0; i < hjs_pkg::JOINT_COUNT; i++) begin
        hc_r[i] <= '0;
      end
    end else begin
      sv_r <= sv_nxt;
      tv_r <= tv_nxt;
      hc_r <= hc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/hjs_lane.sv @@
// ----------------------------------------------------------------------------
// hjs_lane
// One coordinate lane: level/trend store and a five-stage Holt datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module hjs_lane (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 adv,
  input  wire hjs_pkg::mode_t                       in_mode,
  input  wire logic [hjs_pkg::ADDR_W-1:0]           in_addr,
  input  wire logic signed [hjs_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic [hjs_pkg::FACTOR_W-1:0]         factor,
  output logic signed [hjs_pkg::STORE_W-1:0]        level_out
);

  localparam int SW = hjs_pkg::STORE_W;

  // Store: level in the upper half, trend in the lower half
  logic [2*SW-1:0] mem [hjs_pkg::JOINT_COUNT];
  logic [2*SW-1:0] rd_r;

  // Stage registers
  hjs_pkg::mode_t mode1_r, mode2_r, mode3_r, mode4_r, mode5_r;
  logic [hjs_pkg::ADDR_W-1:0] addr1_r, addr2_r, addr3_r, addr4_r, addr5_r;
  logic signed [hjs_pkg::XQ_W-1:0]   x1_r, x2_r, x3_r;
  logic signed [SW-1:0]              s2_r, s3_r, b2_r, b3_r, b4_r, b5_r;
  logic signed [SW-1:0]              snew4_r, snew5_r;
  logic signed [hjs_pkg::DIFF_W-1:0] e2_r, e3_r, e4_r, e5_r, d2_r;
  logic signed [hjs_pkg::TSUM_W-1:0] t2_r, t3_r;
  logic signed [hjs_pkg::PROD_W-1:0] m1_r, m2_r;

  // Combinational per-stage values
  logic signed [SW-1:0]              s_rd, b_rd;
  logic signed [hjs_pkg::DIFF_W-1:0] e1, d2;
  logic signed [hjs_pkg::TSUM_W-1:0] t1;
  logic signed [hjs_pkg::PROD_W-1:0] m1, m2, m1_rnd, m2_rnd;
  logic signed [SW-1:0]              sn, snew3, bn, b_new;
  logic signed [hjs_pkg::SUM_W-1:0]  sum1, sum2;
  logic signed [hjs_pkg::FACTOR_W:0] a_s;

  assign s_rd = rd_r[2*SW-1:SW];
  assign b_rd = rd_r[SW-1:0];
  assign a_s  = {1'b0, factor};

  // Stage 1: X - S (- B), S + B
  always_comb begin
    e1 = hjs_pkg::DIFF_W'(x1_r) - hjs_pkg::DIFF_W'(s_rd);
    if (mode1_r == hjs_pkg::MODE_HOLT) begin
      e1 = e1 - hjs_pkg::DIFF_W'(b_rd);
    end
    t1 = hjs_pkg::TSUM_W'(s_rd) + hjs_pkg::TSUM_W'(b_rd);
  end

  // Stage 2: a * (X - S - B)
  assign m1 = a_s * e2_r;

  // Stage 3: new level, and its step against S + B
  always_comb begin
    m1_rnd = m1_r + hjs_pkg::PROD_W'(32768);
    sum1   = hjs_pkg::SUM_W'(t3_r) +
             hjs_pkg::SUM_W'($signed(m1_rnd[hjs_pkg::PROD_W-1:16]));
    sn     = hjs_pkg::sat_store(sum1);
    d2     = hjs_pkg::DIFF_W'(sn) - hjs_pkg::DIFF_W'(t3_r);
    case (mode3_r)
      hjs_pkg::MODE_HOLT:  snew3 = sn;
      hjs_pkg::MODE_FIRST: snew3 = SW'(x3_r);
      default:             snew3 = s3_r;
    endcase
  end

  // Stage 4: a * (S' - S - B)
  assign m2 = a_s * d2_r;

  // Stage 5: new trend
  always_comb begin
    m2_rnd = m2_r + hjs_pkg::PROD_W'(32768);
    sum2   = hjs_pkg::SUM_W'(b5_r) +
             hjs_pkg::SUM_W'($signed(m2_rnd[hjs_pkg::PROD_W-1:16]));
    bn     = hjs_pkg::sat_store(sum2);
    case (mode5_r)
      hjs_pkg::MODE_HOLT:   b_new = bn;
      hjs_pkg::MODE_SECOND: b_new = hjs_pkg::sat_store(hjs_pkg::SUM_W'(e5_r));
      default:              b_new = b5_r;
    endcase
  end

  assign level_out = snew5_r;

  // Store write as the item leaves stage 5, registered read at accept
  always_ff @(posedge clk) begin
    if (adv && (mode5_r != hjs_pkg::MODE_NONE)) begin
      mem[addr5_r] <= {snew5_r, b_new};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= mem[in_addr];
    end
  end

  // Update kind per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode1_r <= hjs_pkg::MODE_NONE;
      mode2_r <= hjs_pkg::MODE_NONE;
      mode3_r <= hjs_pkg::MODE_NONE;
      mode4_r <= hjs_pkg::MODE_NONE;
      mode5_r <= hjs_pkg::MODE_NONE;
    end else if (adv) begin
      mode1_r <= in_mode;
      mode2_r <= mode1_r;
      mode3_r <= mode2_r;
      mode4_r <= mode3_r;
      mode5_r <= mode4_r;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      addr1_r <= in_addr;
      x1_r    <= {in_sample, 8'd0};

      addr2_r <= addr1_r;
      x2_r    <= x1_r;
      s2_r    <= s_rd;
      b2_r    <= b_rd;
      e2_r    <= e1;
      t2_r    <= t1;

      addr3_r <= addr2_r;
      x3_r    <= x2_r;
      s3_r    <= s2_r;
      b3_r    <= b2_r;
      e3_r    <= e2_r;
      t3_r    <= t2_r;
      m1_r    <= m1;

      addr4_r <= addr3_r;
      snew4_r <= snew3;
      b4_r    <= b3_r;
      e4_r    <= e3_r;
      d2_r    <= d2;

      addr5_r <= addr4_r;
      snew5_r <= snew4_r;
      b5_r    <= b4_r;
      e5_r    <= e4_r;
      m2_r    <= m2;
    end
  end

endmodule

`default_nettype wire

@@ sv/hjs_merge.sv @@
// ----------------------------------------------------------------------------
// hjs_merge
// Merges the five lane levels into one result and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hjs_merge (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                adv,
  input  wire hjs_pkg::stage_ctl_t                 last_ctl,
  input  wire logic signed [hjs_pkg::STORE_W-1:0]  level [hjs_pkg::COORD_COUNT],
  output logic                                     out_tvalid,
  output logic [hjs_pkg::USER_W-1:0]               out_tuser,
  output logic [hjs_pkg::DATA_W-1:0]               out_tdata
);

  localparam int RW = hjs_pkg::STORE_W - 7;   // width after dropping 8 fraction bits

  logic                         vld_r;
  logic [hjs_pkg::USER_W-1:0]   user_r, user_nxt;
  logic [hjs_pkg::DATA_W-1:0]   data_r, data_nxt;
  logic signed [RW-1:0]         rnd [hjs_pkg::COORD_COUNT];

  function automatic logic [15:0] sat_mm(input logic signed [RW-1:0] v);
    logic [15:0] r;
    if (v > RW'(32767)) begin
      r = 16'h7FFF;
    end else if (v < -RW'(32768)) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [11:0] sat_px(input logic signed [RW-1:0] v);
    logic [11:0] r;
    if (v < 0) begin
      r = 12'h000;
    end else if (v > RW'(4095)) begin
      r = 12'hFFF;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

  // Round half up out of Q.8
  always_comb begin
    logic signed [hjs_pkg::STORE_W:0] tmp;
    for (int c = 0; c < hjs_pkg::COORD_COUNT; c++) begin
      tmp    = (hjs_pkg::STORE_W+1)'(level[c]) + (hjs_pkg::STORE_W+1)'(128);
      rnd[c] = tmp[hjs_pkg::STORE_W:8];
    end
  end

  // Pack the result; coordinates read zero for an empty slot
  always_comb begin
    user_nxt = {last_ctl.jvalid, last_ctl.idx};
    data_nxt = '0;
    if (last_ctl.jvalid) begin
      data_nxt[15:0]  = sat_mm(rnd[0]);
      data_nxt[31:16] = sat_mm(rnd[1]);
      data_nxt[47:32] = sat_mm(rnd[2]);
      data_nxt[59:48] = sat_px(rnd[3]);
      data_nxt[71:60] = sat_px(rnd[4]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= last_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      user_r <= user_nxt;
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = user_r;
  assign out_tdata  = data_r;

endmodule

`default_nettype wire
